/* hdl/gsps_pkg.sv */
`timescale 1ns / 1ps

package gsps_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int BYTE_W      = 8;
  localparam int REPLY_KEEP  = 5;

  localparam logic [CFG_W-1:0]  PERIOD_RESET = 16'd16000;
  localparam logic [CFG_W-1:0]  DELAY_RESET  = 16'd200;
  localparam logic [CFG_W-1:0]  NO_PAD_RESET = 16'd0;

  localparam logic [BYTE_W-1:0] CMD_START    = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_POLL     = 8'h42;
  localparam logic [BYTE_W-1:0] CMD_IDLE     = 8'h00;

  localparam logic [BYTE_W-1:0] HDR_ID0      = 8'hff;
  localparam logic [BYTE_W-1:0] HDR_MODE_DIG = 8'h41;
  localparam logic [BYTE_W-1:0] HDR_MODE_ANA = 8'h73;
  localparam logic [BYTE_W-1:0] HDR_ACK      = 8'h5a;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_DELAY  = 2'd1,
    REG_NO_PAD = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_RX   = 1'b1
  } func_t;

  typedef struct packed {
    logic              attention;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              poll_done;
    logic [CFG_W-1:0]  pad_state;
  } result_t;

endpackage

/* hdl/gsps_core.sv */
`timescale 1ns / 1ps

module gsps_core #(
  parameter int POLL_BYTES = 9
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsps_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          step,
  input  logic                          func,
  input  logic [gsps_pkg::BYTE_W-1:0]   rx_byte,
  output gsps_pkg::result_t             result
);
  import gsps_pkg::*;

  localparam int IDX_W = $clog2(POLL_BYTES + 1);

  logic [CFG_W-1:0]  period_r;
  logic [CFG_W-1:0]  delay_r;
  logic [CFG_W-1:0]  no_pad_r;
  logic [CFG_W-1:0]  tick_count_r, tick_count_nxt;
  logic              waiting_r, waiting_nxt;
  logic              attention_r, attention_nxt;
  logic [IDX_W-1:0]  byte_index_r, byte_index_nxt;
  logic [CFG_W-1:0]  last_pad_r, last_pad_nxt;
  logic [BYTE_W-1:0] reply_r [REPLY_KEEP];
  logic [BYTE_W-1:0] reply_view [REPLY_KEEP];

  logic [CFG_W-1:0]  tick_inc;
  logic [CFG_W-1:0]  tick_new;
  logic              period_hit;
  logic              wait_armed;
  logic              delay_hit;
  logic [IDX_W-1:0]  idx_inc;
  logic              poll_last;
  logic [IDX_W-1:0]  cmd_idx;
  logic [BYTE_W-1:0] cmd_byte;
  logic              header_ok;
  logic              send;
  logic              done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      delay_r  <= DELAY_RESET;
      no_pad_r <= NO_PAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PERIOD: period_r <= cfg_wdata;
        REG_DELAY:  delay_r  <= cfg_wdata;
        REG_NO_PAD: no_pad_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign tick_inc   = tick_count_r + 1'b1;
  assign period_hit = (tick_inc == period_r);
  assign tick_new   = period_hit ? '0 : tick_inc;
  assign wait_armed = waiting_r | period_hit;
  assign delay_hit  = (tick_new == delay_r) && wait_armed;

  assign idx_inc   = byte_index_r + 1'b1;
  assign poll_last = (idx_inc == IDX_W'(POLL_BYTES));

  // forward the byte arriving now into the header check
  for (genvar i = 0; i < REPLY_KEEP; i++) begin : g_reply
    assign reply_view[i] = (byte_index_r == IDX_W'(i)) ? rx_byte : reply_r[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < REPLY_KEEP; i++) begin
      if (step && func == FUNC_RX && byte_index_r == IDX_W'(i)) begin
        reply_r[i] <= rx_byte;
      end
    end
  end

  assign header_ok = (reply_view[0] == HDR_ID0) &&
                     ((reply_view[1] == HDR_MODE_DIG) || (reply_view[1] == HDR_MODE_ANA)) &&
                     (reply_view[2] == HDR_ACK);

  assign cmd_idx = (func == FUNC_RX) ? idx_inc : byte_index_r;

  always_comb begin
    if (cmd_idx == IDX_W'(0)) begin
      cmd_byte = CMD_START;
    end else if (cmd_idx == IDX_W'(1)) begin
      cmd_byte = CMD_POLL;
    end else begin
      cmd_byte = CMD_IDLE;
    end
  end

  always_comb begin
    tick_count_nxt = tick_count_r;
    waiting_nxt    = waiting_r;
    attention_nxt  = attention_r;
    byte_index_nxt = byte_index_r;
    last_pad_nxt   = last_pad_r;
    send           = 1'b0;
    done           = 1'b0;
    unique case (func_t'(func))
      FUNC_TICK: begin
        tick_count_nxt = tick_new;
        attention_nxt  = attention_r | period_hit;
        waiting_nxt    = wait_armed & ~delay_hit;
        send           = delay_hit;
      end
      FUNC_RX: begin
        if (poll_last) begin
          attention_nxt  = 1'b0;
          byte_index_nxt = '0;
          done           = 1'b1;
          last_pad_nxt   = header_ok ? ~{reply_view[4], reply_view[3]} : no_pad_r;
        end else begin
          byte_index_nxt = idx_inc;
          send           = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      waiting_r    <= 1'b0;
      attention_r  <= 1'b0;
      byte_index_r <= '0;
      last_pad_r   <= NO_PAD_RESET;
    end else if (step) begin
      tick_count_r <= tick_count_nxt;
      waiting_r    <= waiting_nxt;
      attention_r  <= attention_nxt;
      byte_index_r <= byte_index_nxt;
      last_pad_r   <= last_pad_nxt;
    end
  end

  assign result.attention  = attention_nxt;
  assign result.send_valid = send;
  assign result.send_byte  = send ? cmd_byte : '0;
  assign result.poll_done  = done;
  assign result.pad_state  = last_pad_nxt;

endmodule

/* hdl/gamepad_spi_poll_sequencer.sv */
`timescale 1ns / 1ps

// result path: input register, then result register, from input transaction to result
// throughput: one transaction per cycle; input stalls only while both registers are full
// and the result is stalled
// state update is single pass: compares and one indexed store in the step cycle
// reset (rst_n low, synchronous): pipeline empty, timer and byte index cleared,
// attention released, config back to defaults, pad state equal to the no-pad default

module gamepad_spi_poll_sequencer #(
  parameter int POLL_BYTES = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gsps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsps_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [gsps_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_attention,
  output logic                           out_send_valid,
  output logic [gsps_pkg::BYTE_W-1:0]    out_send_byte,
  output logic                           out_poll_done,
  output logic [gsps_pkg::CFG_W-1:0]     out_pad_state
);
  import gsps_pkg::*;

  logic              in_valid_r;
  logic              func_r;
  logic [BYTE_W-1:0] rx_byte_r;
  logic              out_valid_r;
  result_t           result_r;
  result_t           result;
  logic              advance;
  logic              in_fire;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r    <= in_func;
      rx_byte_r <= in_rx_byte;
    end
  end

  gsps_core #(
    .POLL_BYTES(POLL_BYTES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .step     (advance),
    .func     (func_r),
    .rx_byte  (rx_byte_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_attention  = result_r.attention;
  assign out_send_valid = result_r.send_valid;
  assign out_send_byte  = result_r.send_byte;
  assign out_poll_done  = result_r.poll_done;
  assign out_pad_state  = result_r.pad_state;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import gsps_pkg::*;

  localparam int POLL_LEN    = 9;
  localparam int IDLE_PCT    = 15;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 85;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    func_t             func;
    logic [BYTE_W-1:0] rx;
  } pad_input_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = 1'b0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_attention;
  logic                 out_send_valid;
  logic [BYTE_W-1:0]    out_send_byte;
  logic                 out_poll_done;
  logic [CFG_W-1:0]     out_pad_state;

  // poll sequencer shadow state
  logic [CFG_W-1:0]  m_period, m_delay, m_no_pad;
  logic [CFG_W-1:0]  m_ticks;
  logic              m_armed, m_attn;
  logic [3:0]        m_idx;
  logic [BYTE_W-1:0] m_reply [REPLY_KEEP];
  logic [CFG_W-1:0]  m_pad;

  pad_input_t pad_input_q [$];
  result_t    poll_results_q [$];

  int errors = 0;
  int phase_items = 0;
  int gen_idx = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  bit no_idle = 1'b0;
  bit in_taken = 1'b0;

  gamepad_spi_poll_sequencer #(.POLL_BYTES(POLL_LEN)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_attention(out_attention),
    .out_send_valid(out_send_valid),
    .out_send_byte(out_send_byte),
    .out_poll_done(out_poll_done),
    .out_pad_state(out_pad_state)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BYTE_W-1:0] command_for(logic [3:0] idx);
    case (idx)
      4'd0: return CMD_START;
      4'd1: return CMD_POLL;
      default: return CMD_IDLE;
    endcase
  endfunction

  function automatic result_t poll_step(func_t func, logic [BYTE_W-1:0] rx);
    result_t r;
    r = '0;
    if (func == FUNC_TICK) begin
      m_ticks = m_ticks + 1'b1;
      if (m_ticks == m_period) begin
        m_ticks = '0;
        m_attn  = 1'b1;
        m_armed = 1'b1;
      end
      if (m_ticks == m_delay && m_armed) begin
        m_armed      = 1'b0;
        r.send_valid = 1'b1;
        r.send_byte  = command_for(m_idx);
      end
    end else begin
      if (m_idx < REPLY_KEEP) m_reply[m_idx[2:0]] = rx;
      m_idx = m_idx + 1'b1;
      if (m_idx < POLL_LEN) begin
        r.send_valid = 1'b1;
        r.send_byte  = command_for(m_idx);
      end else begin
        m_attn      = 1'b0;
        m_idx       = '0;
        r.poll_done = 1'b1;
        if (m_reply[0] == HDR_ID0 && m_reply[2] == HDR_ACK &&
            (m_reply[1] == HDR_MODE_DIG || m_reply[1] == HDR_MODE_ANA)) begin
          m_pad = ~{m_reply[4], m_reply[3]};
        end else begin
          m_pad = m_no_pad;
        end
      end
    end
    r.attention = m_attn;
    r.pad_state = m_pad;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               act_val);
    end
  endtask

  task automatic push_item(func_t func, logic [BYTE_W-1:0] rx);
    pad_input_q.push_back('{func, rx});
    phase_items++;
    if (func == FUNC_RX) gen_idx = (gen_idx + 1) % POLL_LEN;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PERIOD: m_period = value;
      REG_DELAY:  m_delay  = value;
      REG_NO_PAD: m_no_pad = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained;
    do @(posedge clk);
    while (pad_input_q.size() != 0 || poll_results_q.size() != 0 || in_valid);
    repeat (4) @(posedge clk);
  endtask

  // ticks up to a poll, then a full exchange; some torn exchanges and loose noise
  task automatic add_sequence(logic [CFG_W-1:0] period);
    int kind;
    int n;
    int len;
    logic [BYTE_W-1:0] reply [POLL_LEN];
    kind = $urandom_range(9);
    n = (period != 0 && period <= 40) ? period + 2 : 6;
    if (kind == 0) begin
      repeat ($urandom_range(6, 1)) push_item(func_t'($urandom_range(1)), BYTE_W'($urandom));
    end else begin
      while (gen_idx != 0) push_item(FUNC_RX, BYTE_W'($urandom));
      repeat ($urandom_range(n, 1)) push_item(FUNC_TICK, BYTE_W'($urandom));
      foreach (reply[i]) reply[i] = BYTE_W'($urandom);
      reply[0] = HDR_ID0;
      reply[1] = $urandom_range(1) ? HDR_MODE_ANA : HDR_MODE_DIG;
      reply[2] = HDR_ACK;
      case ($urandom_range(9))
        0: {reply[4], reply[3]} = '0;
        1: {reply[4], reply[3]} = '1;
        default: ;
      endcase
      if ($urandom_range(3) == 0) reply[$urandom_range(2)] = BYTE_W'($urandom);
      len = (kind == 1) ? $urandom_range(POLL_LEN - 1, 1) : POLL_LEN;
      for (int i = 0; i < len; i++) push_item(FUNC_RX, reply[i]);
    end
  endtask

  task automatic run_phase(logic [CFG_W-1:0] period, logic [CFG_W-1:0] delay,
                           logic [CFG_W-1:0] no_pad, bit calm);
    wait_drained;
    write_reg(REG_PERIOD, period);
    write_reg(REG_DELAY, delay);
    write_reg(REG_NO_PAD, no_pad);
    no_idle = calm;
    if (calm) hold_req++;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) add_sequence(period);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (pad_input_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
      in_valid   <= 1'b1;
      in_func    <= pad_input_q[0].func;
      in_rx_byte <= pad_input_q[0].rx;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      poll_results_q.push_back(poll_step(func_t'(in_func), in_rx_byte));
      void'(pad_input_q.pop_front());
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && $urandom_range(99) < IDLE_PCT;
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (poll_results_q.size() == 0) begin
        errors++;
        $display("%0t: transaction with none expected, expected nothing, actual pad 0x%0h",
                 $time, out_pad_state);
      end else begin
        want = poll_results_q.pop_front();
        check_field("attention", 32'(want.attention), 32'(out_attention));
        check_field("send_valid", 32'(want.send_valid), 32'(out_send_valid));
        check_field("send_byte", 32'(want.send_byte), 32'(out_send_byte));
        check_field("poll_done", 32'(want.poll_done), 32'(out_poll_done));
        check_field("pad_state", 32'(want.pad_state), 32'(out_pad_state));
      end
    end
  end

  initial begin
    logic [BYTE_W-1:0] good_reply [POLL_LEN] = '{HDR_ID0, HDR_MODE_DIG, HDR_ACK, 8'h00,
                                                 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    logic [BYTE_W-1:0] torn_reply [POLL_LEN - 1] = '{HDR_MODE_ANA, HDR_ACK, 8'hFF, 8'h00,
                                                     8'h5A, 8'h00, 8'h00, 8'hFF};
    m_period = PERIOD_RESET;
    m_delay  = DELAY_RESET;
    m_no_pad = NO_PAD_RESET;
    m_pad    = NO_PAD_RESET;
    m_ticks  = '0;
    m_armed  = 1'b0;
    m_attn   = 1'b0;
    m_idx    = '0;
    foreach (m_reply[i]) m_reply[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // delay equal to period, stray byte outside a poll, poll restarted mid exchange
    write_reg(REG_PERIOD, 16'd3);
    write_reg(REG_DELAY, 16'd3);
    write_reg(REG_NO_PAD, 16'hA5C3);
    write_reg(REG_SPARE, 16'hFFFF);
    push_item(FUNC_TICK, 8'hFF);
    push_item(FUNC_TICK, 8'h00);
    push_item(FUNC_TICK, 8'h00);
    foreach (good_reply[i]) push_item(FUNC_RX, good_reply[i]);
    push_item(FUNC_RX, 8'h00);
    repeat (3) push_item(FUNC_TICK, 8'h00);
    foreach (torn_reply[i]) push_item(FUNC_RX, torn_reply[i]);

    run_phase(16'd1, 16'd0, 16'hFFFF, 1'b0);
    run_phase(16'd5, 16'd2, CFG_W'($urandom), 1'b0);
    run_phase(16'd7, 16'd7, CFG_W'($urandom), 1'b0);
    run_phase(16'd12, 16'hFFFF, CFG_W'($urandom), 1'b0);
    run_phase(16'd20, 16'd3, CFG_W'($urandom), 1'b1);

    // zero period: the counter runs on with no poll started
    wait_drained;
    no_idle = 1'b0;
    write_reg(REG_PERIOD, 16'd0);
    write_reg(REG_DELAY, 16'd0);
    write_reg(REG_NO_PAD, CFG_W'($urandom));
    repeat (40) push_item(FUNC_TICK, BYTE_W'($urandom));
    repeat (3) add_sequence(16'd0);

    run_phase(16'hFFFF, 16'd0, 16'd0, 1'b0);
    wait_drained;
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
